// ----- hw/rtl/gbt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gbt_pkg: shared types and constants for the graph traversal engine
// Beat formats, memory request formats, controller states and small helpers.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int FIELD_W      = 5;
  localparam int CFG_W        = 6;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(32);

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_START = 1'b1;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_BFS   = 2'd2,
    FUNC_DFS   = 2'd3
  } func_t;

  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef struct packed {
    func_t              func;
    logic [FIELD_W-1:0] edge_from;
    logic [FIELD_W-1:0] edge_to;
    logic [FIELD_W-1:0] start_vertex;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] visit_vertex;
    logic               status;
    logic               last_flag;
  } out_beat_t;

  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    row_t              wr_data;
  } adj_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] vertex;
    logic [CNT_W-1:0]  resume;
  } work_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    work_entry_t       wr_data;
  } work_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EDGE_RD_A,
    S_EDGE_WR_A,
    S_EDGE_RD_B,
    S_EDGE_WR_B,
    S_ERR,
    S_BFS_INIT,
    S_BFS_POP,
    S_BFS_EMIT,
    S_BFS_ROW,
    S_BFS_SCAN,
    S_DFS_INIT,
    S_DFS_TOP,
    S_DFS_ROW,
    S_DFS_FIND,
    S_DFS_PUSH,
    S_FIN
  } state_t;

  function automatic logic [ADDR_W-1:0] lowest_bit(input row_t r);
    logic [ADDR_W-1:0] idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (r[i]) idx = ADDR_W'(i);
    end
    return idx;
  endfunction

  function automatic row_t vertex_bit(input logic [ADDR_W-1:0] v);
    return row_t'(1) << v;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/gbt_adj_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gbt_adj_mem: adjacency matrix storage
// One row per vertex in a synchronous memory with registered read data.
// Row valid bits let a single clear request empty the whole matrix.
// ----------------------------------------------------------------------------
module gbt_adj_mem (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire gbt_pkg::adj_req_t req,
  output gbt_pkg::row_t          rd_data
);
  import gbt_pkg::*;

  row_t mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid_r;
  row_t rdata_r;
  logic rvalid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (req.clear) begin
        row_valid_r <= '0;
      end else if (req.wr_en) begin
        row_valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_r <= row_valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rvalid_r ? rdata_r : '0;

endmodule
`default_nettype wire

// ----- hw/rtl/gbt_work_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gbt_work_mem: traversal work memory
// Holds the breadth-first queue or the depth-first stack of resume points.
// Read data is registered and holds until the next read.
// ----------------------------------------------------------------------------
module gbt_work_mem (
  input  wire                     clk,
  input  wire gbt_pkg::work_req_t req,
  output gbt_pkg::work_entry_t    rd_data
);
  import gbt_pkg::*;

  work_entry_t mem [MAX_VERTICES];
  work_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/gbt_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gbt_ctrl: traversal sequencer
// Decodes input beats, runs edge updates and both traversals over the two
// memories, and holds the newest vertex back one beat to mark the last one.
// ----------------------------------------------------------------------------
module gbt_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  input  wire gbt_pkg::in_beat_t    in_beat,
  output logic                      in_stall,
  input  wire [gbt_pkg::CFG_W-1:0]  vertex_count,
  input  wire                       out_free,
  output logic                      res_push,
  output gbt_pkg::out_beat_t        res_beat,
  output gbt_pkg::adj_req_t         adj_req,
  input  wire gbt_pkg::row_t        adj_rdata,
  output gbt_pkg::work_req_t        work_req,
  input  wire gbt_pkg::work_entry_t work_rdata
);
  import gbt_pkg::*;

  state_t            state_r, state_nxt;
  in_beat_t          item_r, item_nxt;
  row_t              visited_r, visited_nxt;
  row_t              scan_r, scan_nxt;
  logic [CNT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [ADDR_W-1:0] found_r, found_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [ADDR_W-1:0] pend_vertex_r, pend_vertex_nxt;

  logic [CNT_W-1:0]  live_n;
  row_t              live_mask;
  logic              accept;
  logic              can_emit;
  logic              edge_ok;
  logic              start_ok;
  row_t              dfs_cand;
  logic [ADDR_W-1:0] scan_pick;
  logic [ADDR_W-1:0] dfs_pick;
  logic [ADDR_W-1:0] emit_vertex;
  logic              emit_now;

  always_comb begin
    if (int'(vertex_count) >= MAX_VERTICES) begin
      live_n = CNT_W'(MAX_VERTICES);
    end else begin
      live_n = CNT_W'(vertex_count);
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live_mask[i] = (CNT_W'(i) < live_n);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_emit  = !pend_valid_r || out_free;
  assign edge_ok   = (CNT_W'(item_r.edge_from) < live_n) && (CNT_W'(item_r.edge_to) < live_n);
  assign start_ok  = CNT_W'(in_beat.start_vertex) < live_n;
  assign dfs_cand  = adj_rdata & ~visited_r & live_mask
                     & ({MAX_VERTICES{1'b1}} << work_rdata.resume);
  assign scan_pick = lowest_bit(scan_r);
  assign dfs_pick  = lowest_bit(dfs_cand);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_beat.func)
            FUNC_CLEAR: state_nxt = S_IDLE;
            FUNC_EDGE:  state_nxt = S_EDGE_RD_A;
            FUNC_BFS:   state_nxt = start_ok ? S_BFS_INIT : S_ERR;
            FUNC_DFS:   state_nxt = start_ok ? S_DFS_INIT : S_ERR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_EDGE_RD_A: state_nxt = edge_ok ? S_EDGE_WR_A : S_IDLE;
      S_EDGE_WR_A: state_nxt = S_EDGE_RD_B;
      S_EDGE_RD_B: state_nxt = S_EDGE_WR_B;
      S_EDGE_WR_B: state_nxt = S_IDLE;
      S_ERR:       state_nxt = out_free ? S_IDLE : S_ERR;
      S_BFS_INIT:  state_nxt = S_BFS_POP;
      S_BFS_POP:   state_nxt = (head_r == tail_r) ? S_FIN : S_BFS_EMIT;
      S_BFS_EMIT:  state_nxt = can_emit ? S_BFS_ROW : S_BFS_EMIT;
      S_BFS_ROW:   state_nxt = S_BFS_SCAN;
      S_BFS_SCAN:  state_nxt = (scan_r == '0) ? S_BFS_POP : S_BFS_SCAN;
      S_DFS_INIT:  state_nxt = can_emit ? S_DFS_TOP : S_DFS_INIT;
      S_DFS_TOP:   state_nxt = (depth_r == '0) ? S_FIN : S_DFS_ROW;
      S_DFS_ROW:   state_nxt = S_DFS_FIND;
      S_DFS_FIND: begin
        if (dfs_cand == '0) begin
          state_nxt = S_DFS_TOP;
        end else if (can_emit) begin
          state_nxt = S_DFS_PUSH;
        end
      end
      S_DFS_PUSH:  state_nxt = S_DFS_TOP;
      S_FIN:       state_nxt = out_free ? S_IDLE : S_FIN;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt        = item_r;
    visited_nxt     = visited_r;
    scan_nxt        = scan_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    depth_nxt       = depth_r;
    found_nxt       = found_r;
    pend_valid_nxt  = pend_valid_r;
    pend_vertex_nxt = pend_vertex_r;
    adj_req         = '0;
    work_req        = '0;
    res_push        = 1'b0;
    res_beat        = '0;
    emit_now        = 1'b0;
    emit_vertex     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_beat;
          if (in_beat.func == FUNC_CLEAR) begin
            adj_req.clear = 1'b1;
          end
        end
      end
      S_EDGE_RD_A: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = ADDR_W'(item_r.edge_from);
      end
      S_EDGE_WR_A: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = ADDR_W'(item_r.edge_from);
        adj_req.wr_data = adj_rdata | vertex_bit(ADDR_W'(item_r.edge_to));
      end
      S_EDGE_RD_B: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = ADDR_W'(item_r.edge_to);
      end
      S_EDGE_WR_B: begin
        adj_req.wr_en   = 1'b1;
        adj_req.wr_addr = ADDR_W'(item_r.edge_to);
        adj_req.wr_data = adj_rdata | vertex_bit(ADDR_W'(item_r.edge_from));
      end
      S_ERR: begin
        res_push              = out_free;
        res_beat.visit_vertex = '0;
        res_beat.status       = STATUS_BAD_START;
        res_beat.last_flag    = 1'b1;
      end
      S_BFS_INIT: begin
        visited_nxt            = vertex_bit(ADDR_W'(item_r.start_vertex));
        work_req.wr_en         = 1'b1;
        work_req.wr_addr       = '0;
        work_req.wr_data       = '{vertex: ADDR_W'(item_r.start_vertex), resume: '0};
        head_nxt               = '0;
        tail_nxt               = CNT_W'(1);
      end
      S_BFS_POP: begin
        if (head_r != tail_r) begin
          work_req.rd_en   = 1'b1;
          work_req.rd_addr = head_r[ADDR_W-1:0];
          head_nxt         = head_r + CNT_W'(1);
        end
      end
      S_BFS_EMIT: begin
        if (can_emit) begin
          emit_now        = 1'b1;
          emit_vertex     = work_rdata.vertex;
          adj_req.rd_en   = 1'b1;
          adj_req.rd_addr = work_rdata.vertex;
        end
      end
      S_BFS_ROW: begin
        scan_nxt = adj_rdata & ~visited_r & live_mask;
      end
      S_BFS_SCAN: begin
        if (scan_r != '0) begin
          visited_nxt      = visited_r | vertex_bit(scan_pick);
          scan_nxt         = scan_r & ~vertex_bit(scan_pick);
          work_req.wr_en   = 1'b1;
          work_req.wr_addr = tail_r[ADDR_W-1:0];
          work_req.wr_data = '{vertex: scan_pick, resume: '0};
          tail_nxt         = tail_r + CNT_W'(1);
        end
      end
      S_DFS_INIT: begin
        if (can_emit) begin
          emit_now         = 1'b1;
          emit_vertex      = ADDR_W'(item_r.start_vertex);
          visited_nxt      = vertex_bit(ADDR_W'(item_r.start_vertex));
          work_req.wr_en   = 1'b1;
          work_req.wr_addr = '0;
          work_req.wr_data = '{vertex: ADDR_W'(item_r.start_vertex), resume: '0};
          depth_nxt        = CNT_W'(1);
        end
      end
      S_DFS_TOP: begin
        if (depth_r != '0) begin
          work_req.rd_en   = 1'b1;
          work_req.rd_addr = ADDR_W'(depth_r - CNT_W'(1));
        end
      end
      S_DFS_ROW: begin
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = work_rdata.vertex;
      end
      S_DFS_FIND: begin
        if (dfs_cand == '0) begin
          depth_nxt = depth_r - CNT_W'(1);
        end else if (can_emit) begin
          emit_now         = 1'b1;
          emit_vertex      = dfs_pick;
          visited_nxt      = visited_r | vertex_bit(dfs_pick);
          found_nxt        = dfs_pick;
          work_req.wr_en   = 1'b1;
          work_req.wr_addr = ADDR_W'(depth_r - CNT_W'(1));
          work_req.wr_data = '{vertex: work_rdata.vertex,
                               resume: CNT_W'(dfs_pick) + CNT_W'(1)};
        end
      end
      S_DFS_PUSH: begin
        work_req.wr_en   = 1'b1;
        work_req.wr_addr = depth_r[ADDR_W-1:0];
        work_req.wr_data = '{vertex: found_r, resume: '0};
        depth_nxt        = depth_r + CNT_W'(1);
      end
      S_FIN: begin
        if (out_free) begin
          res_push              = 1'b1;
          res_beat.visit_vertex = FIELD_W'(pend_vertex_r);
          res_beat.status       = STATUS_OK;
          res_beat.last_flag    = 1'b1;
          pend_valid_nxt        = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // A new vertex pushes the one held back out as a non-final beat.
    if (emit_now) begin
      if (pend_valid_r) begin
        res_push              = 1'b1;
        res_beat.visit_vertex = FIELD_W'(pend_vertex_r);
        res_beat.status       = STATUS_OK;
        res_beat.last_flag    = 1'b0;
      end
      pend_valid_nxt  = 1'b1;
      pend_vertex_nxt = emit_vertex;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      depth_r      <= '0;
      visited_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      depth_r      <= depth_nxt;
      visited_r    <= visited_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    scan_r        <= scan_nxt;
    found_r       <= found_nxt;
    pend_vertex_r <= pend_vertex_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/graph_bfs_dfs_traversal.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal: adjacency matrix graph with BFS and DFS traversal
// Input beats (in_valid/in_stall, payload in_beat) clear the graph, add an
// undirected edge, or start a breadth-first or depth-first traversal. Each
// traversal returns one output beat per reached vertex (out_valid/out_stall,
// payload out_beat), lowest neighbor first, with last_flag on the final beat.
// A start vertex outside the vertex count returns a single error beat.
// cfg_we/cfg_wdata write the vertex count; the user must write it only while
// the block is idle, which the block itself does not enforce. One item is
// worked on at a time; in_stall is high until it is finished.
// Both memories have registered read data. A BFS reads one adjacency row per
// reached vertex; a DFS rereads the row of the stack top on each step.
// Each vertex is held back one beat so that the final one can be flagged.
// An output register parts the channels: a stalled beat holds, and the
// engine waits only when it must hand over a new beat.
// Reset empties the graph, sets the vertex count to 32 and drops any
// pending beat.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire gbt_pkg::in_beat_t   in_beat,
  output logic                     out_valid,
  input  wire                      out_stall,
  output gbt_pkg::out_beat_t       out_beat,
  input  wire                      cfg_we,
  input  wire [gbt_pkg::CFG_W-1:0] cfg_wdata
);
  import gbt_pkg::*;

  logic [CFG_W-1:0] vertex_count_r;
  logic             out_valid_r;
  out_beat_t        out_beat_r;
  logic             out_free;
  logic             res_push;
  out_beat_t        res_beat;
  adj_req_t         adj_req;
  row_t             adj_rdata;
  work_req_t        work_req;
  work_entry_t      work_rdata;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VERTEX_COUNT_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        vertex_count_r <= cfg_wdata;
      end
      if (res_push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  gbt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_beat      (in_beat),
    .in_stall     (in_stall),
    .vertex_count (vertex_count_r),
    .out_free     (out_free),
    .res_push     (res_push),
    .res_beat     (res_beat),
    .adj_req      (adj_req),
    .adj_rdata    (adj_rdata),
    .work_req     (work_req),
    .work_rdata   (work_rdata)
  );

  gbt_adj_mem u_adj_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (adj_req),
    .rd_data (adj_rdata)
  );

  gbt_work_mem u_work_mem (
    .clk     (clk),
    .req     (work_req),
    .rd_data (work_rdata)
  );

  // A new beat never overwrites one that is still stalled.
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> out_free)
    else $error("result pushed into a full output register");

  // A traversal request keeps the input side closed on the next cycle.
  a_traversal_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_beat.func == FUNC_BFS || in_beat.func == FUNC_DFS))
    |=> in_stall)
    else $error("input accepted right after a traversal request");

  // An error beat is always final and carries vertex zero.
  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status == STATUS_BAD_START)
    |-> (out_beat.last_flag && out_beat.visit_vertex == '0))
    else $error("malformed error beat");

  // The adjacency memory never sees a read and a write in the same cycle.
  a_adj_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(adj_req.rd_en && adj_req.wr_en))
    else $error("adjacency read and write in the same cycle");

endmodule
`default_nettype wire
